>>> rtl/vrta_pkg.sv
`timescale 1ns / 1ps

package vrta_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 512;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int TBL_CW        = $clog2(TABLE_ENTRIES + 1);

  // Bytes reserved at the pool base for the table itself.
  localparam logic [31:0] RESERVED_BYTES = 32'd4096;
  localparam logic [31:0] POOL_LIMIT_RST = 32'd4194304;

  // Configuration register indexes.
  localparam int         CFG_IDX_W      = 1;
  localparam logic [0:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [0:0] CFG_POOL_LIMIT = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_CHECK   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_REL_SCAN,
    S_REL_SHIFT,
    S_CHK_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [31:0] length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] region_start;
    logic        legitimate;
    logic [31:0] freed_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    entry_t            wdata;
    logic [TBL_AW-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/vrta_mem.sv
`timescale 1ns / 1ps

module vrta_mem (
  input  logic              clk,
  input  vrta_pkg::mem_req_t mem_req,
  output vrta_pkg::entry_t  mem_rdata
);
  import vrta_pkg::*;

  entry_t ram [TABLE_ENTRIES];
  entry_t rdata_r;

  // One write port and one read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      ram[mem_req.waddr] <= mem_req.wdata;
    end
    rdata_r <= ram[mem_req.raddr];
  end

  assign mem_rdata = rdata_r;

endmodule

>>> rtl/vrta_ctrl.sv
`timescale 1ns / 1ps

module vrta_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vrta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vrta_pkg::in_item_t                  in_item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output vrta_pkg::out_item_t                 res_item,
  output vrta_pkg::mem_req_t                  mem_req,
  input  vrta_pkg::entry_t                    mem_rdata
);
  import vrta_pkg::*;

  state_t            state_r, state_nxt;
  logic [TBL_CW-1:0] count_r, count_nxt;
  logic [31:0]       bytes_r, bytes_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [31:0]       limit_r, limit_nxt;
  logic [TBL_CW-1:0] ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [TBL_CW-1:0] pidx_r, pidx_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       len_r, len_nxt;
  out_item_t         res_r, res_nxt;

  logic [TBL_CW-1:0] last_idx;
  logic [TBL_CW-1:0] shift_dst;
  logic              scan_more;
  logic [32:0]       need_bytes;
  logic [31:0]       next_start;
  logic [31:0]       chk_off;

  assign last_idx   = count_r - TBL_CW'(1);
  assign shift_dst  = pidx_r - TBL_CW'(1);
  assign scan_more  = (ptr_r < count_r);
  assign need_bytes = {1'b0, bytes_r} + {1'b0, in_item.length};
  assign next_start = mem_rdata.start + mem_rdata.size;
  assign chk_off    = addr_r - mem_rdata.start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      count_r <= TBL_CW'(1);
      bytes_r <= RESERVED_BYTES;
      base_r  <= '0;
      limit_r <= POOL_LIMIT_RST;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bytes_r <= bytes_nxt;
      base_r  <= base_nxt;
      limit_r <= limit_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    pidx_r <= pidx_nxt;
    addr_r <= addr_nxt;
    len_r  <= len_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    bytes_nxt = bytes_r;
    base_nxt  = base_r;
    limit_nxt = limit_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_req       = '0;
    mem_req.raddr = ptr_r[TBL_AW-1:0];

    unique case (state_r)
      S_INIT: begin
        mem_req.we          = 1'b1;
        mem_req.waddr       = '0;
        mem_req.wdata.start = base_r;
        mem_req.wdata.size  = RESERVED_BYTES;
        state_nxt           = S_IDLE;
      end

      S_IDLE: begin
        in_ready      = 1'b1;
        mem_req.raddr = last_idx[TBL_AW-1:0];
        if (in_valid) begin
          addr_nxt = in_item.address;
          len_nxt  = in_item.length;
          res_nxt  = '0;
          pend_nxt = 1'b0;
          ptr_nxt  = '0;
          unique case (mode_t'(in_item.mode))
            MODE_ALLOC: begin
              priority if (in_item.length == 32'd0) begin
                res_nxt.status = ST_ZERO;
                state_nxt      = S_RESP;
              end else if (count_r >= TBL_CW'(TABLE_ENTRIES)) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_RESP;
              end else if (need_bytes > {1'b0, limit_r}) begin
                res_nxt.status = ST_EXHAUSTED;
                state_nxt      = S_RESP;
              end else if (count_r == '0) begin
                mem_req.we           = 1'b1;
                mem_req.waddr        = '0;
                mem_req.wdata.start  = base_r;
                mem_req.wdata.size   = in_item.length;
                count_nxt            = TBL_CW'(1);
                bytes_nxt            = need_bytes[31:0];
                res_nxt.region_start = base_r;
                state_nxt            = S_RESP;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            MODE_RELEASE: state_nxt = S_REL_SCAN;
            MODE_CHECK:   state_nxt = S_CHK_SCAN;
            MODE_NONE:    state_nxt = S_RESP;
            default:      state_nxt = S_RESP;
          endcase
        end
      end

      S_ALLOC: begin
        mem_req.we           = 1'b1;
        mem_req.waddr        = count_r[TBL_AW-1:0];
        mem_req.wdata.start  = next_start;
        mem_req.wdata.size   = len_r;
        count_nxt            = count_r + TBL_CW'(1);
        bytes_nxt            = bytes_r + len_r;
        res_nxt.region_start = next_start;
        state_nxt            = S_RESP;
      end

      S_REL_SCAN: begin
        pend_nxt = scan_more;
        if (scan_more) begin
          ptr_nxt  = ptr_r + TBL_CW'(1);
          pidx_nxt = ptr_r;
        end
        if (pend_r && mem_rdata.start == addr_r) begin
          res_nxt.freed_length = mem_rdata.size;
          bytes_nxt            = bytes_r - mem_rdata.size;
          ptr_nxt              = pidx_r + TBL_CW'(1);
          pend_nxt             = 1'b0;
          state_nxt            = S_REL_SHIFT;
        end else if (!pend_r && !scan_more) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end
      end

      S_REL_SHIFT: begin
        // Reads run one entry ahead of the writes that close the gap.
        pend_nxt = scan_more;
        if (scan_more) begin
          ptr_nxt  = ptr_r + TBL_CW'(1);
          pidx_nxt = ptr_r;
        end
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = shift_dst[TBL_AW-1:0];
          mem_req.wdata = mem_rdata;
        end else if (!scan_more) begin
          count_nxt = last_idx;
          state_nxt = S_RESP;
        end
      end

      S_CHK_SCAN: begin
        pend_nxt = scan_more;
        if (scan_more) begin
          ptr_nxt  = ptr_r + TBL_CW'(1);
          pidx_nxt = ptr_r;
        end
        if (pend_r && chk_off < mem_rdata.size) begin
          res_nxt.legitimate = 1'b1;
          pend_nxt           = 1'b0;
          state_nxt          = S_RESP;
        end else if (!pend_r && !scan_more) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_INIT;
    endcase

    // A new pool base rebuilds the table from scratch.
    if (cfg_we) begin
      if (cfg_index == CFG_POOL_BASE) begin
        base_nxt  = cfg_wdata;
        count_nxt = TBL_CW'(1);
        bytes_nxt = RESERVED_BYTES;
        pend_nxt  = 1'b0;
        state_nxt = S_INIT;
      end else begin
        limit_nxt = cfg_wdata;
      end
    end
  end

  assign res_item = res_r;

endmodule

>>> rtl/virtual_region_table_allocator_top.sv
`timescale 1ns / 1ps
// Throughput: one transaction at a time; the next one is accepted in the cycle after the result
// leaves the controller. The single read port of the table memory reads one entry per cycle
// across search and shift.
// Reset: synchronous, active low; after reset (and after a pool_base write) the controller
// writes the reserved entry 0 in its init state, during which in_ready stays low. No other
// clearing pass is needed.

module virtual_region_table_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vrta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vrta_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vrta_pkg::out_item_t            out_item
);
  import vrta_pkg::*;

  // The table lives in a single synchronous memory of (start, size) pairs. The controller
  // reads an entry, inspects it in the next cycle and writes back where the table changes.
  mem_req_t  mem_req;
  entry_t    mem_rdata;

  // Handoff from the controller to the output register.
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;

  // Output register: holds a finished result so that the controller can return to idle and
  // accept the next transaction while the consumer stalls.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  vrta_mem u_mem (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  vrta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // The slot takes a new result when it is empty or is being drained in this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import vrta_pkg::*;

  // Slowest search plus compaction on a full table, with some margin.
  localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 16;
  // About 580 transactions at worst take under 1.5 ms of simulated time; the
  // watchdog allows several times that.
  localparam longint TIMEOUT_NS = 64'd6_000_000;
  localparam int BACKLOG_DEPTH = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  virtual_region_table_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  // Requests waiting to be driven, and replies predicted for transactions that
  // the block has already accepted, oldest first.
  in_item_t  request_backlog[$];
  out_item_t pending_replies[$];
  int        mismatch_count = 0;

  // Shadow copy of the configuration and of the region table. It is updated
  // at the clock edge at which a request transaction is accepted, so it always
  // reflects exactly what the block has seen so far.
  logic [31:0] reg_pool_base  = 32'd0;
  logic [31:0] reg_pool_limit = POOL_LIMIT_RST;
  logic [31:0] rgn_start [TABLE_ENTRIES];
  logic [31:0] rgn_len   [TABLE_ENTRIES];
  int unsigned rgn_count;
  logic [31:0] bytes_used;

  // Empties the table down to the reserved entry at the pool base. The block
  // does the same at reset and whenever pool_base is written.
  function automatic void init_region_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      rgn_start[i] = '0;
      rgn_len[i]   = '0;
    end
    rgn_start[0] = reg_pool_base;
    rgn_len[0]   = RESERVED_BYTES;
    rgn_count    = 1;
    bytes_used   = RESERVED_BYTES;
  endfunction

  // Applies one request to the shadow table and returns the reply the block
  // must produce for it.
  function automatic out_item_t apply_region_request(in_item_t req);
    out_item_t   rsp;
    int unsigned hit;
    logic [31:0] offset;
    rsp = '0;
    case (req.mode)
      MODE_ALLOC: begin
        // Zero length wins over a full table, which wins over pool exhaustion.
        if (req.length == 32'd0) begin
          rsp.status = ST_ZERO;
        end else if (rgn_count >= TABLE_ENTRIES) begin
          rsp.status = ST_FULL;
        end else if ({1'b0, bytes_used} + {1'b0, req.length} > {1'b0, reg_pool_limit}) begin
          // The sum is taken one bit wider so that it cannot wrap.
          rsp.status = ST_EXHAUSTED;
        end else begin
          rsp.status = ST_OK;
          // Once even the reserved entry is gone, allocation restarts at the base.
          if (rgn_count == 0) begin
            rsp.region_start = reg_pool_base;
          end else begin
            rsp.region_start = rgn_start[rgn_count - 1] + rgn_len[rgn_count - 1];
          end
          rgn_start[rgn_count] = rsp.region_start;
          rgn_len[rgn_count]   = req.length;
          rgn_count++;
          bytes_used += req.length;
        end
      end
      MODE_RELEASE: begin
        // The lowest-numbered entry with a matching start is the one released.
        hit = rgn_count;
        for (int i = 0; i < rgn_count; i++) begin
          if (hit == rgn_count && rgn_start[i] == req.address) hit = i;
        end
        if (hit == rgn_count) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          rsp.status       = ST_OK;
          rsp.freed_length = rgn_len[hit];
          bytes_used      -= rgn_len[hit];
          for (int i = hit; i + 1 < rgn_count; i++) begin
            rgn_start[i] = rgn_start[i + 1];
            rgn_len[i]   = rgn_len[i + 1];
          end
          rgn_start[rgn_count - 1] = '0;
          rgn_len[rgn_count - 1]   = '0;
          rgn_count--;
        end
      end
      MODE_CHECK: begin
        // Region membership is tested modulo 2^32, so regions may wrap.
        rsp.status = ST_OK;
        for (int i = 0; i < rgn_count; i++) begin
          offset = req.address - rgn_start[i];
          if (offset < rgn_len[i]) rsp.legitimate = 1'b1;
        end
      end
      default: begin
        // The unused mode leaves the table alone and answers all zeros.
      end
    endcase
    return rsp;
  endfunction

  // Builds a random request from the current shadow table. Releases mostly
  // name a live region start and checks mostly land inside a live region, so
  // that the search and the compaction are exercised; the rest is noise.
  function automatic in_item_t random_item(int unsigned alloc_pct, logic [31:0] max_len,
                                           bit wide_ok);
    in_item_t    req;
    int unsigned pick;
    int unsigned idx;
    req.mode    = MODE_CHECK;
    req.address = $urandom;
    req.length  = $urandom;
    if ($urandom_range(0, 99) < alloc_pct) begin
      req.mode = MODE_ALLOC;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        req.length = '0;
      end else if (pick != 1 || !wide_ok) begin
        req.length = $urandom_range(1, max_len);
      end
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        req.mode = MODE_RELEASE;
        if (rgn_count > 0 && $urandom_range(0, 6) != 0) begin
          req.address = rgn_start[$urandom_range(0, rgn_count - 1)];
        end
      end else if (pick < 18) begin
        if (rgn_count > 0) begin
          idx  = $urandom_range(0, rgn_count - 1);
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            req.address = rgn_start[idx] + $urandom_range(0, rgn_len[idx] - 1);
          end else if (pick < 8) begin
            // The first address just past the region.
            req.address = rgn_start[idx] + rgn_len[idx];
          end
        end
      end else begin
        req.mode = MODE_NONE;
      end
    end
    return req;
  endfunction

  // Adds a request to the backlog, keeping it short so that random requests
  // are built from a nearly current view of the table.
  task automatic queue_request(input logic [1:0] m, input logic [31:0] a,
                               input logic [31:0] l);
    in_item_t req;
    req.mode    = m;
    req.address = a;
    req.length  = l;
    @(negedge clk);
    while (request_backlog.size() >= BACKLOG_DEPTH) @(negedge clk);
    request_backlog.push_back(req);
  endtask

  // Returns once every request has been accepted and every reply has arrived.
  task automatic wait_idle();
    @(negedge clk);
    while (request_backlog.size() != 0 || in_valid || pending_replies.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // One write on the configuration port; the shadow copy follows at the edge
  // at which the block takes the write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POOL_BASE) begin
      reg_pool_base = val;
      init_region_table();
    end else begin
      reg_pool_limit = val;
    end
  endtask

  // Request driver. It sends in bursts of random length separated by random
  // gaps, and predicts the reply of each transaction as it is accepted. The
  // burst and gap counters belong to this block alone.
  int send_burst = 0;
  int send_gap   = 0;

  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_replies.push_back(apply_region_request(in_item));
      end
      // A new request may be presented only once the current one is gone.
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          in_item  <= request_backlog.pop_front();
          in_valid <= 1'b1;
          send_burst--;
          if (send_burst <= 0) begin
            send_burst = $urandom_range(1, 16);
            send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor. The receiver alternates ready and stalled runs of random
  // length, with an occasional long ready stretch, and compares every accepted
  // reply transaction with the oldest prediction.
  int recv_left     = 0;
  bit recv_ready_on = 1'b0;

  always @(posedge clk) begin : reply_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $error("reply transaction with no request outstanding: %h", out_item);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            mismatch_count++;
          end
          if (out_item.region_start !== want.region_start) begin
            $error("region_start: expected %h, actual %h",
                   want.region_start, out_item.region_start);
            mismatch_count++;
          end
          if (out_item.legitimate !== want.legitimate) begin
            $error("legitimate: expected %0d, actual %0d",
                   want.legitimate, out_item.legitimate);
            mismatch_count++;
          end
          if (out_item.freed_length !== want.freed_length) begin
            $error("freed_length: expected %h, actual %h",
                   want.freed_length, out_item.freed_length);
            mismatch_count++;
          end
        end
      end
      if (recv_left > 0) begin
        recv_left--;
      end else begin
        recv_ready_on = !recv_ready_on;
        if (recv_ready_on) begin
          recv_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
        end else begin
          recv_left = $urandom_range(1, 4);
        end
      end
      out_ready <= recv_ready_on;
    end
  end

  // Stimulus sequence and end of test.
  initial begin : stimulus
    in_item_t req;
    init_region_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: base 0, a 4 MiB pool. Zero length, a length too large
    // for the pool, an allocation that fills the pool exactly, checks on both
    // sides of the edge, a missing address and the unused mode.
    queue_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0);
    queue_request(MODE_ALLOC, $urandom, 32'hFFFF_FFFF);
    queue_request(MODE_ALLOC, $urandom, 32'd1);
    queue_request(MODE_ALLOC, $urandom, 32'h003F_EFFF);
    queue_request(MODE_ALLOC, $urandom, 32'd1);
    queue_request(MODE_CHECK, 32'h0000_0000, $urandom);
    queue_request(MODE_CHECK, 32'h003F_FFFF, $urandom);
    queue_request(MODE_CHECK, 32'h0040_0000, $urandom);
    queue_request(MODE_RELEASE, 32'h0000_1234, $urandom);
    queue_request(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Release everything, the reserved entry included; on the empty table a
    // check finds nothing and the next allocation lands on the pool base.
    queue_request(MODE_RELEASE, 32'h0000_1001, $urandom);
    queue_request(MODE_RELEASE, 32'h0000_0000, $urandom);
    queue_request(MODE_RELEASE, 32'h0000_1000, $urandom);
    queue_request(MODE_CHECK, 32'h0000_0000, $urandom);
    queue_request(MODE_ALLOC, $urandom, 32'd7);
    wait_idle();

    // Largest limit. Start addresses wrap past the top of the address space
    // until a new region starts on the same address as the reserved entry;
    // release must then take the lower entry first. The pool sum must not
    // wrap either.
    write_reg(CFG_POOL_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_POOL_BASE, 32'h0000_0000);
    queue_request(MODE_ALLOC, $urandom, 32'h8000_0000);
    queue_request(MODE_ALLOC, $urandom, 32'h0000_1000);
    queue_request(MODE_RELEASE, 32'h0000_1000, $urandom);
    queue_request(MODE_ALLOC, $urandom, 32'h7FFF_E000);
    queue_request(MODE_ALLOC, $urandom, 32'h0000_0100);
    queue_request(MODE_ALLOC, $urandom, 32'hFFFF_FFFF);
    queue_request(MODE_RELEASE, 32'h0000_0000, $urandom);
    queue_request(MODE_RELEASE, 32'h0000_0000, $urandom);
    queue_request(MODE_CHECK, 32'hFFFF_FFFF, $urandom);
    wait_idle();

    // Highest base, so the reserved entry wraps through zero, and a limit
    // below the reserved page, so that no allocation can ever succeed.
    write_reg(CFG_POOL_LIMIT, 32'h0000_0000);
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
    queue_request(MODE_ALLOC, $urandom, 32'd5);
    queue_request(MODE_CHECK, 32'hFFFF_FFFF, $urandom);
    queue_request(MODE_CHECK, 32'h0000_0FFE, $urandom);
    queue_request(MODE_CHECK, 32'h0000_0FFF, $urandom);
    wait_idle();
    write_reg(CFG_POOL_LIMIT, RESERVED_BYTES);
    queue_request(MODE_ALLOC, $urandom, 32'd1);
    wait_idle();

    // Random mix on a small pool, so that exhaustion shows up, with some
    // full-width lengths.
    write_reg(CFG_POOL_LIMIT, RESERVED_BYTES + $urandom_range(32'h8000, 32'h4_0000));
    write_reg(CFG_POOL_BASE, $urandom);
    repeat (24) begin
      req = random_item(45, 32'h4000, 1'b1);
      queue_request(req.mode, req.address, req.length);
    end
    wait_idle();

    // Fill the table with small regions on an unlimited pool, then keep going
    // on the full table: allocations must report it full, while releases and
    // checks walk the whole table. The shadow count lags the backlog, so a
    // few fill allocations already land on the full table.
    write_reg(CFG_POOL_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_POOL_BASE, $urandom);
    repeat (527) begin
      if (rgn_count < TABLE_ENTRIES) begin
        queue_request(MODE_ALLOC, $urandom, $urandom_range(1, 32'h1_0000));
      end else begin
        req = random_item(35, 32'h1_0000, 1'b0);
        queue_request(req.mode, req.address, req.length);
      end
    end
    wait_idle();

    // Let any stray reply surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
